>>> rtl/tsts_pkg.sv
// Package for the time-slot task scheduler: word types, action codes and defaults.
// Used by tsts_ctrl, tsts_out_reg, the top level and the checker; depends on nothing.
package tsts_pkg;

  localparam int TSTS_TABLE_DEPTH  = 64;
  localparam int TSTS_TASK_ID_BITS = 8;

  localparam logic [1:0] ACT_WRITE = 2'd0;
  localparam logic [1:0] ACT_TICK  = 2'd1;
  localparam logic [1:0] ACT_FETCH = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  typedef struct packed {
    logic [1:0] action;
    logic [5:0] entry_index;
    logic [7:0] entry_task;
  } tsts_in_t;

  typedef struct packed {
    logic        task_valid;
    logic [7:0]  task_id;
    logic [5:0]  slot_start;
    logic [47:0] tick_count;
  } tsts_out_t;

endpackage

>>> rtl/tsts_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module tsts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/tsts_out_reg.sv
// Output register that holds one result word until the consumer takes it.
// Depends on tsts_pkg for the result word type.
module tsts_out_reg
  import tsts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  tsts_out_t word_i,
  output logic      ready_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output tsts_out_t out_word_o
);

  logic      valid_q;
  logic      valid_d;
  tsts_out_t word_q;

  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = push_i ? 1'b1 : (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && ready_o) begin
      word_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

endmodule

>>> rtl/tsts_ctrl.sv
// Sequencer of the scheduler: decodes each input word, keeps the slot state and
// walks the task table RAM one entry per cycle. Depends on tsts_pkg.
module tsts_ctrl
  import tsts_pkg::*;
#(
  parameter int TABLE_DEPTH  = TSTS_TABLE_DEPTH,
  parameter int TASK_ID_BITS = TSTS_TASK_ID_BITS,
  localparam int IDX_W = $clog2(TABLE_DEPTH),
  localparam int POS_W = IDX_W + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  tsts_in_t                in_word_i,
  input  logic [15:0]             slot_len_i,
  output logic                    rd_en_o,
  output logic [IDX_W-1:0]        rd_addr_o,
  input  logic [TASK_ID_BITS-1:0] rd_data_i,
  output logic                    wr_en_o,
  output logic [IDX_W-1:0]        wr_addr_o,
  output logic [TASK_ID_BITS-1:0] wr_data_o,
  output logic                    res_valid_o,
  output tsts_out_t               res_word_o,
  input  logic                    res_ready_i
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FETCH = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  localparam logic [POS_W-1:0] DEPTH_P = POS_W'(TABLE_DEPTH);

  logic [2:0]       state_q, state_d;
  logic [15:0]      div_cnt_q, div_cnt_d;
  logic             started_q, started_d;
  logic [IDX_W-1:0] cur_slot_q, cur_slot_d;
  logic             saved_valid_q, saved_valid_d;
  logic [IDX_W-1:0] saved_slot_q, saved_slot_d;
  logic             next_valid_q, next_valid_d;
  logic [POS_W-1:0] next_pos_q, next_pos_d;
  logic [47:0]      ticks_q, ticks_d;
  logic [POS_W-1:0] walk_pos_q, walk_pos_d;
  logic             hit_q, hit_d;
  logic             task_valid_q, task_valid_d;
  logic [7:0]       task_id_q, task_id_d;

  logic [POS_W-1:0] fetch_pos;
  logic [POS_W-1:0] walk_nxt;
  logic [15:0]      limit;
  logic             rd_nz;
  logic             same_slot;

  assign same_slot = saved_valid_q && (saved_slot_q == cur_slot_q);
  assign walk_nxt  = walk_pos_q + POS_W'(1);
  assign limit     = (slot_len_i == 16'd0) ? 16'd0 : slot_len_i - 16'd1;
  assign rd_nz     = (rd_data_i != '0);

  always_comb begin
    state_d       = state_q;
    div_cnt_d     = div_cnt_q;
    started_d     = started_q;
    cur_slot_d    = cur_slot_q;
    saved_valid_d = saved_valid_q;
    saved_slot_d  = saved_slot_q;
    next_valid_d  = next_valid_q;
    next_pos_d    = next_pos_q;
    ticks_d       = ticks_q;
    walk_pos_d    = walk_pos_q;
    hit_d         = hit_q;
    task_valid_d  = task_valid_q;
    task_id_d     = task_id_q;
    rd_en_o       = 1'b0;
    rd_addr_o     = '0;
    wr_en_o       = 1'b0;
    wr_addr_o     = IDX_W'(in_word_i.entry_index);
    wr_data_o     = TASK_ID_BITS'(in_word_i.entry_task);
    fetch_pos     = same_slot ? next_pos_q : {1'b0, cur_slot_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          task_valid_d = 1'b0;
          task_id_d    = 8'd0;
          state_d      = S_DONE;
          unique case (in_word_i.action)
            ACT_WRITE: begin
              wr_en_o = (int'(in_word_i.entry_index) < TABLE_DEPTH);
            end
            ACT_TICK: begin
              ticks_d = ticks_q + 48'd1;
              if (div_cnt_q >= limit) begin
                if (next_valid_q && (next_pos_q < DEPTH_P)) begin
                  rd_en_o    = 1'b1;
                  rd_addr_o  = next_pos_q[IDX_W-1:0];
                  walk_pos_d = next_pos_q;
                  state_d    = S_WALK;
                end else begin
                  cur_slot_d = '0;
                  started_d  = 1'b1;
                  div_cnt_d  = 16'd0;
                end
              end else begin
                div_cnt_d = div_cnt_q + 16'd1;
              end
            end
            ACT_FETCH: begin
              if (started_q) begin
                if (!same_slot) begin
                  saved_valid_d = 1'b1;
                  saved_slot_d  = cur_slot_q;
                  next_pos_d    = {1'b0, cur_slot_q};
                  next_valid_d  = 1'b1;
                end
                hit_d     = (fetch_pos < DEPTH_P);
                rd_en_o   = (fetch_pos < DEPTH_P);
                rd_addr_o = fetch_pos[IDX_W-1:0];
                state_d   = S_FETCH;
              end
            end
            ACT_NONE: begin
              state_d = S_DONE;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (hit_q && rd_nz) begin
          task_valid_d = 1'b1;
          task_id_d    = 8'(rd_data_i);
          next_pos_d   = next_pos_q + POS_W'(1);
        end
        state_d = S_DONE;
      end
      S_WALK: begin
        if (walk_nxt >= DEPTH_P) begin
          cur_slot_d = '0;
          started_d  = 1'b1;
          div_cnt_d  = 16'd0;
          state_d    = S_DONE;
        end else begin
          rd_en_o    = 1'b1;
          rd_addr_o  = walk_nxt[IDX_W-1:0];
          walk_pos_d = walk_nxt;
          state_d    = rd_nz ? S_WALK : S_CHECK;
        end
      end
      S_CHECK: begin
        cur_slot_d = rd_nz ? walk_pos_q[IDX_W-1:0] : '0;
        started_d  = 1'b1;
        div_cnt_d  = 16'd0;
        state_d    = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      div_cnt_q     <= 16'd0;
      started_q     <= 1'b0;
      cur_slot_q    <= '0;
      saved_valid_q <= 1'b0;
      saved_slot_q  <= '0;
      next_valid_q  <= 1'b0;
      next_pos_q    <= '0;
      ticks_q       <= 48'd0;
      walk_pos_q    <= '0;
      hit_q         <= 1'b0;
      task_valid_q  <= 1'b0;
      task_id_q     <= 8'd0;
    end else begin
      state_q       <= state_d;
      div_cnt_q     <= div_cnt_d;
      started_q     <= started_d;
      cur_slot_q    <= cur_slot_d;
      saved_valid_q <= saved_valid_d;
      saved_slot_q  <= saved_slot_d;
      next_valid_q  <= next_valid_d;
      next_pos_q    <= next_pos_d;
      ticks_q       <= ticks_d;
      walk_pos_q    <= walk_pos_d;
      hit_q         <= hit_d;
      task_valid_q  <= task_valid_d;
      task_id_q     <= task_id_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_word_o = '{
    task_valid: task_valid_q,
    task_id:    task_id_q,
    slot_start: 6'(cur_slot_q),
    tick_count: ticks_q
  };

endmodule

>>> rtl/time_slot_task_scheduler.sv
// Top level of the time-slot task scheduler: config register, sequencer, table RAM
// and output register. Depends on tsts_pkg, tsts_ctrl, tsts_ram and tsts_out_reg.
//
// The block takes one input word at a time and returns exactly one result word for
// each. A write, a no-op, a tick without slot expiry or a fetch before the first slot
// goes from the idle state straight to the done state; a fetch passes through the
// fetch state, which takes the table entry. A tick that expires the slot walks the
// task table through the single read port of the table RAM, one entry per cycle,
// from the last fetch position through the delimiter that ends its slot and then
// through the check state, or until the walk runs to the end of the table. The done
// state holds while the output register is full and stalled. The result sits in an
// output register, so the next word is accepted while one result is stalled. A new
// slot length may be written at any time the block is idle.
module time_slot_task_scheduler
  import tsts_pkg::*;
#(
  parameter int TABLE_DEPTH  = TSTS_TABLE_DEPTH,
  parameter int TASK_ID_BITS = TSTS_TASK_ID_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  tsts_in_t    in_word_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output tsts_out_t   out_word_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [15:0]             slot_len_q;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic [TASK_ID_BITS-1:0] rd_data;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [TASK_ID_BITS-1:0] wr_data;
  logic                    res_valid;
  logic                    res_ready;
  tsts_out_t               res_word;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_len_q <= 16'd1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      slot_len_q <= cfg_data_i;
    end
  end

  tsts_ctrl #(
    .TABLE_DEPTH  (TABLE_DEPTH),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_word_i      (in_word_i),
    .slot_len_i     (slot_len_q),
    .rd_en_o        (rd_en),
    .rd_addr_o      (rd_addr),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .res_valid_o    (res_valid),
    .res_word_o     (res_word),
    .res_ready_i    (res_ready)
  );

  tsts_ram #(
    .WIDTH (TASK_ID_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  tsts_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .word_i      (res_word),
    .ready_o     (res_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

>>> rtl/tsts_checker.sv
// Port-level checker for the time-slot task scheduler and its bind to the top level.
// Depends on tsts_pkg and time_slot_task_scheduler.
module tsts_checker
  import tsts_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input tsts_in_t    in_word_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input tsts_out_t   out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("Stalled result word was dropped.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("Stalled result word changed.");

  a_no_task_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.task_valid |-> out_word_o.task_id == 8'd0)
    else $error("Result without a task carries a nonzero task id.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("Input accepted again before the previous word was processed.");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_word_i))
    else $error("Stalled input word was withdrawn or changed.");

endmodule

bind time_slot_task_scheduler tsts_checker u_tsts_checker (.*);
